### hdl/pcir_pkg.sv
// Shared widths, constants and helper functions of the contact impulse resolver.
package pcir_pkg;

   localparam int CW   = 21;            // bits per vector component
   localparam int FRAC = 10;            // fraction bits of a component
   localparam int VW   = 63;            // packed vector field width
   localparam int IMW  = 24;            // inverse mass width
   localparam int TSW  = 17;            // time step width
   localparam int RSW  = 17;            // restitution width
   localparam int PW   = 21;            // penetration width

   localparam logic signed [TSW-1:0] TS_RESET = 17'sd1092;

   // Share factor divider: one quotient bit per pipeline step.
   localparam int SHW        = 17;
   localparam int TW         = IMW + 1;
   localparam int DIV_STEPS  = SHW;
   localparam int PRE_STAGES = 5;
   localparam int DLY        = DIV_STEPS - PRE_STAGES;

   // Datapath widths, derived from the component width and the other field widths.
   localparam int DFW  = CW + 1;                  // component difference
   localparam int PDW  = DFW + CW;                // difference times normal
   localparam int SEPW = PDW + 2;                 // three-term dot product
   localparam int NS0W = SEPW + 1;                // restitution product, shifted
   localparam int ACW  = SEPW + TSW;              // acceleration term times time step
   localparam int RPW  = RSW + 1 + ACW - 16;      // restitution times acceleration term
   localparam int NSW  = RPW - 16 + 1;            // new separating velocity
   localparam int DELW = SEPW + 2;                // velocity change along the normal
   localparam int KW   = DELW + SHW - 26;         // per-particle impulse
   localparam int MW   = PW - 1 + SHW - 16;       // per-particle penetration share
   localparam int PKW  = CW + KW + 1;             // normal times impulse
   localparam int PMW  = CW + MW + 1;             // normal times penetration share

   localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic [VW-1:0]        vec_type;

   function automatic comp_type get_comp(input vec_type w, input int unsigned i);
      return comp_type'(w[i*CW +: CW]);
   endfunction

   function automatic comp_type sat_comp(input logic signed [63:0] v);
      comp_type r;
      if (v > CMAX) begin
         r = comp_type'(CMAX);
      end else if (v < CMIN) begin
         r = comp_type'(CMIN);
      end else begin
         r = comp_type'(v[CW-1:0]);
      end
      return r;
   endfunction

   function automatic vec_type pack3(input comp_type c0, input comp_type c1,
                                     input comp_type c2);
      vec_type r;
      r = '0;
      r[0 +: CW]    = c0;
      r[CW +: CW]   = c1;
      r[2*CW +: CW] = c2;
      return r;
   endfunction

endpackage

### hdl/pcir_if.sv
// Valid/ready channel interfaces for contact beats and result beats.
interface pcir_req_if
   import pcir_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VW-1:0]         vel_a;
   logic [VW-1:0]         vel_b;
   logic [VW-1:0]         acc_a;
   logic [VW-1:0]         acc_b;
   logic [IMW-1:0]        inv_mass_a;
   logic [IMW-1:0]        inv_mass_b;
   logic [VW-1:0]         normal;
   logic signed [PW-1:0]  penetration;
   logic [RSW-1:0]        restitution;
   logic                  has_b;

   modport source (output valid, vel_a, vel_b, acc_a, acc_b, inv_mass_a, inv_mass_b,
                   normal, penetration, restitution, has_b, input ready);
   modport sink   (input valid, vel_a, vel_b, acc_a, acc_b, inv_mass_a, inv_mass_b,
                   normal, penetration, restitution, has_b, output ready);
endinterface

interface pcir_rsp_if
   import pcir_pkg::*;
();
   logic          valid;
   logic          ready;
   logic [VW-1:0] new_vel_a;
   logic [VW-1:0] new_vel_b;
   logic [VW-1:0] move_a;
   logic [VW-1:0] move_b;
   logic          velocity_applied;
   logic          position_applied;

   modport source (output valid, new_vel_a, new_vel_b, move_a, move_b,
                   velocity_applied, position_applied, input ready);
   modport sink   (input valid, new_vel_a, new_vel_b, move_a, move_b,
                   velocity_applied, position_applied, output ready);
endinterface

### hdl/pcir_div.sv
// Pipelined restoring divider that forms the inverse mass share factors.
module pcir_div
   import pcir_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [IMW-1:0] ima,
   input  logic [IMW-1:0] imb,
   input  logic           hb,
   output logic [SHW-1:0] sh_a,
   output logic [SHW-1:0] sh_b
);

   typedef struct packed {
      logic [TW:0]    rem_a;
      logic [TW:0]    rem_b;
      logic [SHW-1:0] q_a;
      logic [SHW-1:0] q_b;
      logic [TW-1:0]  tim;
   } div_stage_type;

   div_stage_type st_ff [DIV_STEPS];
   div_stage_type st_in [DIV_STEPS];
   div_stage_type prev  [DIV_STEPS];

   // The first step compares the undivided inverse mass; later steps shift in zeros.
   function automatic div_stage_type div_step(input div_stage_type p, input logic first);
      div_stage_type r;
      logic [TW:0]   ra;
      logic [TW:0]   rb;
      logic [TW:0]   t;
      ra = first ? p.rem_a : {p.rem_a[TW-1:0], 1'b0};
      rb = first ? p.rem_b : {p.rem_b[TW-1:0], 1'b0};
      t  = {1'b0, p.tim};
      r.tim = p.tim;
      if (ra >= t) begin
         r.rem_a = ra - t;
         r.q_a   = {p.q_a[SHW-2:0], 1'b1};
      end else begin
         r.rem_a = ra;
         r.q_a   = {p.q_a[SHW-2:0], 1'b0};
      end
      if (rb >= t) begin
         r.rem_b = rb - t;
         r.q_b   = {p.q_b[SHW-2:0], 1'b1};
      end else begin
         r.rem_b = rb;
         r.q_b   = {p.q_b[SHW-2:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      prev[0].rem_a = (TW+1)'(ima);
      prev[0].rem_b = hb ? (TW+1)'(imb) : '0;
      prev[0].q_a   = '0;
      prev[0].q_b   = '0;
      prev[0].tim   = TW'(ima) + (hb ? TW'(imb) : '0);
      for (int k = 1; k < DIV_STEPS; k++) begin
         prev[k] = st_ff[k-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         st_in[k] = div_step(prev[k], k == 0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign sh_a = st_ff[DIV_STEPS-1].q_a;
   assign sh_b = st_ff[DIV_STEPS-1].q_b;

endmodule

### hdl/particle_contact_impulse_resolver.sv
// Top level of the particle contact impulse resolver pipeline.
//
// Usage: each beat on the req channel carries one contact (velocities,
// accelerations and inverse masses of particles A and B, the normal, the
// penetration depth and the restitution). Each accepted beat yields exactly
// one beat on the rsp channel with the resolved velocities, the position
// corrections and two flags that tell whether an impulse and a penetration
// correction were applied. Results leave in the order the contacts came in.
// The csr port writes the frame time step; write it only while the block
// holds no contact in flight.
// Throughput is one contact per cycle while the output is not stalled. The
// latency is set by the 17-step share factor divider, one quotient bit per
// stage, which the dot product and impulse stages run beside and then wait
// on.
// Reset clears every valid bit and loads the default time step of 1092
// (about 1/60 s); no result is shown until new beats arrive.
// When the receiver stalls, the whole pipeline holds in place and req.ready
// drops, so no beat is lost or repeated; it starts again as soon as the
// waiting result is taken.
module particle_contact_impulse_resolver
   import pcir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic signed [TSW-1:0] csr_wdata,
   pcir_req_if.sink              req,
   pcir_rsp_if.source            rsp
);

   typedef struct {
      vec_type              va;
      vec_type              vb;
      vec_type              aa;
      vec_type              ab;
      vec_type              n;
      logic signed [PW-1:0] pen;
      logic [RSW-1:0]       rest;
      logic                 hb;
      logic [IMW-1:0]       ima;
      logic [IMW-1:0]       imb;
   } s1_type;

   typedef struct {
      vec_type               va;
      vec_type               vb;
      vec_type               n;
      logic signed [PW-1:0]  pen;
      logic [RSW-1:0]        rest;
      logic                  hb;
      logic                  ok;
      logic signed [PDW-1:0] pv [3];
      logic signed [PDW-1:0] pa [3];
   } s2_type;

   typedef struct {
      vec_type                va;
      vec_type                vb;
      vec_type                n;
      logic signed [PW-1:0]   pen;
      logic [RSW-1:0]         rest;
      logic                   hb;
      logic                   ok;
      logic signed [SEPW-1:0] sep;
      logic signed [SEPW-1:0] dacc;
   } s3_type;

   typedef struct {
      vec_type                va;
      vec_type                vb;
      vec_type                n;
      logic signed [PW-1:0]   pen;
      logic [RSW-1:0]         rest;
      logic                   hb;
      logic                   ok;
      logic signed [SEPW-1:0] sep;
      logic [NS0W-1:0]        nsep0;
      logic signed [ACW-1:0]  accp;
   } s4_type;

   typedef struct {
      vec_type                va;
      vec_type                vb;
      vec_type                n;
      logic signed [PW-1:0]   pen;
      logic                   hb;
      logic                   ok;
      logic signed [SEPW-1:0] sep;
      logic [NS0W-1:0]        nsep0;
      logic                   acs_neg;
      logic signed [RPW-1:0]  rprod;
   } s5_type;

   typedef struct {
      vec_type         va;
      vec_type         vb;
      vec_type         n;
      logic [PW-2:0]   pen_u;
      logic            hb;
      logic            vapp;
      logic            papp;
      logic [DELW-1:0] delta;
   } s6_type;

   typedef struct {
      vec_type       va;
      vec_type       vb;
      vec_type       n;
      logic          hb;
      logic          vapp;
      logic          papp;
      logic [KW-1:0] ka;
      logic [KW-1:0] kb;
      logic [MW-1:0] ma;
      logic [MW-1:0] mb;
   } j1_type;

   typedef struct {
      vec_type               va;
      vec_type               vb;
      logic                  hb;
      logic                  vapp;
      logic                  papp;
      logic signed [PKW-1:0] pka [3];
      logic signed [PKW-1:0] pkb [3];
      logic signed [PMW-1:0] pma [3];
      logic signed [PMW:0]   pmb [3];
   } j2_type;

   typedef struct packed {
      vec_type nva;
      vec_type nvb;
      vec_type mva;
      vec_type mvb;
      logic    vflag;
      logic    pflag;
   } out_type;

   logic signed [TSW-1:0] ts_ff;
   logic                  adv;

   s1_type  s1_ff;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s6_type  dly_ff [DLY];
   j1_type  j1_ff, j1_in;
   j2_type  j2_ff, j2_in;
   out_type out_ff, out_in;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic [DLY-1:0] dly_vld_ff;
   logic j1_vld_ff, j2_vld_ff, out_vld_ff;

   logic [SHW-1:0] sh_a;
   logic [SHW-1:0] sh_b;

   // The pipeline moves as a whole unless a finished result is held up.
   assign adv       = !(out_vld_ff && !rsp.ready);
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff <= TS_RESET;
      end else if (csr_we) begin
         ts_ff <= csr_wdata;
      end
   end

   // Relative velocity and acceleration against the normal, one product per lane.
   always_comb begin
      logic signed [DFW-1:0] dv;
      logic signed [DFW-1:0] da;
      s2_in.va   = s1_ff.va;
      s2_in.vb   = s1_ff.vb;
      s2_in.n    = s1_ff.n;
      s2_in.pen  = s1_ff.pen;
      s2_in.rest = s1_ff.rest;
      s2_in.hb   = s1_ff.hb;
      s2_in.ok   = !ts_ff[TSW-1] &&
                   !(s1_ff.ima == '0 && (!s1_ff.hb || s1_ff.imb == '0));
      for (int i = 0; i < 3; i++) begin
         dv = DFW'(get_comp(s1_ff.va, i)) - (s1_ff.hb ? DFW'(get_comp(s1_ff.vb, i)) : '0);
         da = DFW'(get_comp(s1_ff.aa, i)) - (s1_ff.hb ? DFW'(get_comp(s1_ff.ab, i)) : '0);
         s2_in.pv[i] = dv * get_comp(s1_ff.n, i);
         s2_in.pa[i] = da * get_comp(s1_ff.n, i);
      end
   end

   // Dot products: separating velocity and relative acceleration along the normal.
   always_comb begin
      s3_in.va   = s2_ff.va;
      s3_in.vb   = s2_ff.vb;
      s3_in.n    = s2_ff.n;
      s3_in.pen  = s2_ff.pen;
      s3_in.rest = s2_ff.rest;
      s3_in.hb   = s2_ff.hb;
      s3_in.ok   = s2_ff.ok;
      s3_in.sep  = SEPW'(s2_ff.pv[0]) + SEPW'(s2_ff.pv[1]) + SEPW'(s2_ff.pv[2]);
      s3_in.dacc = SEPW'(s2_ff.pa[0]) + SEPW'(s2_ff.pa[1]) + SEPW'(s2_ff.pa[2]);
   end

   // Bounce term from restitution, and the acceleration term over one frame.
   always_comb begin
      logic [SEPW-1:0]     negsep;
      logic [SEPW+RSW-1:0] bprod;
      negsep = SEPW'(-s3_ff.sep);
      bprod  = negsep * s3_ff.rest;
      s4_in.va    = s3_ff.va;
      s4_in.vb    = s3_ff.vb;
      s4_in.n     = s3_ff.n;
      s4_in.pen   = s3_ff.pen;
      s4_in.rest  = s3_ff.rest;
      s4_in.hb    = s3_ff.hb;
      s4_in.ok    = s3_ff.ok;
      s4_in.sep   = s3_ff.sep;
      s4_in.nsep0 = bprod[SEPW+RSW-1:16];
      s4_in.accp  = s3_ff.dacc * ts_ff;
   end

   // Resting-contact correction: restitution times the acceleration term.
   always_comb begin
      s5_in.va      = s4_ff.va;
      s5_in.vb      = s4_ff.vb;
      s5_in.n       = s4_ff.n;
      s5_in.pen     = s4_ff.pen;
      s5_in.hb      = s4_ff.hb;
      s5_in.ok      = s4_ff.ok;
      s5_in.sep     = s4_ff.sep;
      s5_in.nsep0   = s4_ff.nsep0;
      s5_in.acs_neg = s4_ff.accp[ACW-1];
      s5_in.rprod   = $signed({1'b0, s4_ff.rest}) * $signed(s4_ff.accp[ACW-1:16]);
   end

   // New separating velocity, clamped at zero, and the change along the normal.
   always_comb begin
      logic signed [NSW-1:0] nsep;
      logic signed [NSW-1:0] rterm;
      logic signed [NSW-1:0] diff;
      rterm = NSW'($signed(s5_ff.rprod[RPW-1:16]));
      nsep  = NSW'($signed({1'b0, s5_ff.nsep0}));
      if (s5_ff.acs_neg) begin
         nsep = nsep + rterm;
         if (nsep < 0) begin
            nsep = '0;
         end
      end
      diff = nsep - NSW'(s5_ff.sep);
      s6_in.va    = s5_ff.va;
      s6_in.vb    = s5_ff.vb;
      s6_in.n     = s5_ff.n;
      s6_in.pen_u = s5_ff.pen[PW-2:0];
      s6_in.hb    = s5_ff.hb;
      s6_in.vapp  = s5_ff.ok && (s5_ff.sep <= 0);
      s6_in.papp  = s5_ff.ok && (s5_ff.pen > 0);
      s6_in.delta = diff[DELW-1:0];
   end

   pcir_div u_div (
      .clock (clock),
      .en    (adv),
      .ima   (s1_ff.ima),
      .imb   (s1_ff.imb),
      .hb    (s1_ff.hb),
      .sh_a  (sh_a),
      .sh_b  (sh_b)
   );

   // Join with the divider: split impulse and penetration by inverse mass share.
   always_comb begin
      logic [DELW+SHW-1:0]   kfa;
      logic [DELW+SHW-1:0]   kfb;
      logic [PW-1+SHW-1:0]   mfa;
      logic [PW-1+SHW-1:0]   mfb;
      kfa = dly_ff[DLY-1].delta * sh_a;
      kfb = dly_ff[DLY-1].delta * sh_b;
      mfa = dly_ff[DLY-1].pen_u * sh_a;
      mfb = dly_ff[DLY-1].pen_u * sh_b;
      j1_in.va   = dly_ff[DLY-1].va;
      j1_in.vb   = dly_ff[DLY-1].vb;
      j1_in.n    = dly_ff[DLY-1].n;
      j1_in.hb   = dly_ff[DLY-1].hb;
      j1_in.vapp = dly_ff[DLY-1].vapp;
      j1_in.papp = dly_ff[DLY-1].papp;
      j1_in.ka   = kfa[DELW+SHW-1:26];
      j1_in.kb   = kfb[DELW+SHW-1:26];
      j1_in.ma   = mfa[PW-1+SHW-1:16];
      j1_in.mb   = mfb[PW-1+SHW-1:16];
   end

   // Per-component products with the normal.
   always_comb begin
      logic signed [PMW-1:0] pb;
      j2_in.va   = j1_ff.va;
      j2_in.vb   = j1_ff.vb;
      j2_in.hb   = j1_ff.hb;
      j2_in.vapp = j1_ff.vapp;
      j2_in.papp = j1_ff.papp;
      for (int i = 0; i < 3; i++) begin
         j2_in.pka[i] = get_comp(j1_ff.n, i) * $signed({1'b0, j1_ff.ka});
         j2_in.pkb[i] = get_comp(j1_ff.n, i) * $signed({1'b0, j1_ff.kb});
         j2_in.pma[i] = get_comp(j1_ff.n, i) * $signed({1'b0, j1_ff.ma});
         pb           = get_comp(j1_ff.n, i) * $signed({1'b0, j1_ff.mb});
         j2_in.pmb[i] = -((PMW+1)'(pb));
      end
   end

   // Apply the changes, saturate each component and choose what is shown.
   always_comb begin
      comp_type ca [3];
      comp_type cb [3];
      comp_type ma [3];
      comp_type mb [3];
      for (int i = 0; i < 3; i++) begin
         ca[i] = sat_comp(64'(get_comp(j2_ff.va, i)) + 64'(j2_ff.pka[i] >>> FRAC));
         cb[i] = sat_comp(64'(get_comp(j2_ff.vb, i)) - 64'(j2_ff.pkb[i] >>> FRAC));
         ma[i] = sat_comp(64'(j2_ff.pma[i] >>> FRAC));
         mb[i] = sat_comp(64'(j2_ff.pmb[i] >>> FRAC));
      end
      out_in.nva   = j2_ff.vapp ? pack3(ca[0], ca[1], ca[2]) : j2_ff.va;
      out_in.nvb   = (j2_ff.vapp && j2_ff.hb) ? pack3(cb[0], cb[1], cb[2]) : j2_ff.vb;
      out_in.mva   = j2_ff.papp ? pack3(ma[0], ma[1], ma[2]) : '0;
      out_in.mvb   = (j2_ff.papp && j2_ff.hb) ? pack3(mb[0], mb[1], mb[2]) : '0;
      out_in.vflag = j2_ff.vapp;
      out_in.pflag = j2_ff.papp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         dly_vld_ff <= '0;
         j1_vld_ff  <= 1'b0;
         j2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= req.valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         dly_vld_ff <= {dly_vld_ff[DLY-2:0], s6_vld_ff};
         j1_vld_ff  <= dly_vld_ff[DLY-1];
         j2_vld_ff  <= j1_vld_ff;
         out_vld_ff <= j2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.va   <= req.vel_a;
         s1_ff.vb   <= req.vel_b;
         s1_ff.aa   <= req.acc_a;
         s1_ff.ab   <= req.acc_b;
         s1_ff.n    <= req.normal;
         s1_ff.pen  <= req.penetration;
         s1_ff.rest <= req.restitution;
         s1_ff.hb   <= req.has_b;
         s1_ff.ima  <= req.inv_mass_a;
         s1_ff.imb  <= req.inv_mass_b;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         s5_ff      <= s5_in;
         s6_ff      <= s6_in;
         dly_ff[0]  <= s6_ff;
         for (int k = 1; k < DLY; k++) begin
            dly_ff[k] <= dly_ff[k-1];
         end
         j1_ff      <= j1_in;
         j2_ff      <= j2_in;
         out_ff     <= out_in;
      end
   end

   assign rsp.valid            = out_vld_ff;
   assign rsp.new_vel_a        = out_ff.nva;
   assign rsp.new_vel_b        = out_ff.nvb;
   assign rsp.move_a           = out_ff.mva;
   assign rsp.move_b           = out_ff.mvb;
   assign rsp.velocity_applied = out_ff.vflag;
   assign rsp.position_applied = out_ff.pflag;

endmodule

### hdl/pcir_checker.sv
// Port-level checks for the contact impulse resolver and their bind.
module pcir_checker
   import pcir_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input logic [VW-1:0] new_vel_a,
   input logic [VW-1:0] move_a,
   input logic [VW-1:0] move_b,
   input logic          position_applied
);

   // A reset leaves no result beat on the output.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // A held result beat stays, and its new velocity of A and its move of A keep their values.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_vel_a) && $stable(move_a))
      else $error("stalled result beat changed");

   // The input side takes beats exactly when the output is not blocked.
   a_ready : assert property (@(posedge clock) disable iff (reset)
      req_ready == !(rsp_valid && !rsp_ready))
      else $error("input ready does not follow the output stall");

   // Without a penetration correction both moves are zero.
   a_no_move : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !position_applied |-> move_a == '0 && move_b == '0)
      else $error("move reported without a correction");

endmodule

bind particle_contact_impulse_resolver pcir_checker u_pcir_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .new_vel_a        (rsp.new_vel_a),
   .move_a           (rsp.move_a),
   .move_b           (rsp.move_b),
   .position_applied (rsp.position_applied)
);
